// ===== design/frs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package frs_pkg;

  // default sizing
  localparam int unsigned SLOTS_DEF       = 256;
  localparam int unsigned RECORD_BITS_DEF = 64;

  // operation codes
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DELETED  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_UNFILLED = 2'd3;

endpackage
`default_nettype wire

// ===== design/frs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module frs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== design/fixed_slot_record_store_free_list_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Fixed-slot record store with a last-in-first-out free list.
// Input channel (in_valid/in_ready): in_mode selects add, read or delete;
// in_slot_index names the slot for read and delete; in_record_word is the
// record stored by add. Result channel (out_valid/out_ready): one item per
// input item, carrying out_status, out_placed_slot and out_read_word.
// Each item passes an accept step, which issues the reads of the record
// memory and of the link/mark memory, and then an execute step, which
// checks, writes back and loads the output register once that register
// is free. A new item is accepted only after the previous one has left
// the execute step, set by the read-then-write turn around the memories.
// If the receiver stalls while a result waits in the output register, the
// next item is still accepted and its reads issued; it then holds in the
// execute step, with no memory write, until the output register frees.
// Synchronous reset empties the free list and clears the fill count; the
// memories need no clearing, as no entry is used before it is written.
module fixed_slot_record_store_free_list_core
  import frs_pkg::*;
#(
  parameter int unsigned SLOTS       = SLOTS_DEF,
  parameter int unsigned RECORD_BITS = RECORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_slot_index,
  input  wire logic [63:0] in_record_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_placed_slot,
  output logic [63:0]      out_read_word
);

  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned PTR_W  = $clog2(SLOTS + 1);
  localparam int unsigned CMP_W  = (PTR_W > 8) ? PTR_W : 8;
  localparam int unsigned META_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] NONE_MARK = PTR_W'(SLOTS);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                 state_r, state_nxt;
  logic [PTR_W-1:0]       head_r, head_nxt;
  logic [PTR_W-1:0]       fill_r, fill_nxt;
  logic [1:0]             mode_r;
  logic [CMP_W-1:0]       slot_r;
  logic [RECORD_BITS-1:0] word_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             status_r, status_nxt;
  logic [7:0]             placed_r, placed_nxt;
  logic [63:0]            rword_r, rword_nxt;

  logic                   accept;
  logic                   fire;
  logic [CMP_W-1:0]       slot_in_c;
  logic [CMP_W-1:0]       target_c;

  logic                   rec_we;
  logic [IDX_W-1:0]       rec_waddr;
  logic [IDX_W-1:0]       rec_raddr;
  logic [RECORD_BITS-1:0] rec_rdata;
  logic                   meta_we;
  logic [IDX_W-1:0]       meta_waddr;
  logic [META_W-1:0]      meta_wdata;
  logic [IDX_W-1:0]       meta_raddr;
  logic [META_W-1:0]      meta_rdata;
  logic [PTR_W-1:0]       link_rd;

  assign slot_in_c = CMP_W'(in_slot_index);
  assign accept    = in_valid && in_ready;
  assign fire      = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign in_ready  = (state_r == S_IDLE);
  assign link_rd   = meta_rdata[PTR_W-1:0];

  // read addresses: add looks at the head slot's link, others at the given slot
  assign rec_raddr  = IDX_W'(slot_in_c);
  assign meta_raddr = (in_mode == MODE_ADD) ? IDX_W'(head_r) : IDX_W'(slot_in_c);

  frs_ram #(
    .WIDTH (RECORD_BITS),
    .DEPTH (SLOTS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (word_r),
    .re    (accept),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  // link and deleted mark of each slot: {mark, link}
  frs_ram #(
    .WIDTH (META_W),
    .DEPTH (SLOTS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (accept),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  // execute step: check, write back, build the result item
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    placed_nxt    = placed_r;
    rword_nxt     = rword_r;
    rec_we        = 1'b0;
    rec_waddr     = IDX_W'(slot_r);
    meta_we       = 1'b0;
    meta_waddr    = IDX_W'(slot_r);
    meta_wdata    = {1'b1, head_r};
    target_c      = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          placed_nxt    = '0;
          rword_nxt     = '0;
          case (mode_r)
            MODE_ADD: begin
              if (head_r < NONE_MARK) begin
                // reuse the most recently freed slot
                target_c = CMP_W'(head_r);
                head_nxt = (link_rd > NONE_MARK) ? NONE_MARK : link_rd;
              end else if (fill_r < NONE_MARK) begin
                // append at the fill count
                target_c = CMP_W'(fill_r);
                fill_nxt = fill_r + PTR_W'(1);
              end else begin
                status_nxt = ST_FULL;
              end
              if (status_nxt == ST_OK) begin
                rec_we     = 1'b1;
                rec_waddr  = IDX_W'(target_c);
                meta_we    = 1'b1;
                meta_waddr = IDX_W'(target_c);
                meta_wdata = {1'b0, head_r};
                placed_nxt = target_c[7:0];
              end
            end
            MODE_READ: begin
              if (slot_r < CMP_W'(fill_r)) begin
                rword_nxt = 64'(rec_rdata);
              end else begin
                status_nxt = ST_UNFILLED;
              end
            end
            MODE_DELETE: begin
              if (slot_r >= CMP_W'(fill_r)) begin
                status_nxt = ST_UNFILLED;
              end else if (meta_rdata[META_W-1]) begin
                status_nxt = ST_DELETED;
              end else begin
                // push the slot onto the free list
                meta_we  = 1'b1;
                head_nxt = PTR_W'(slot_r);
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, list pointers and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NONE_MARK;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
    placed_r <= placed_nxt;
    rword_r  <= rword_nxt;
    if (accept) begin
      mode_r <= in_mode;
      slot_r <= slot_in_c;
      word_r <= RECORD_BITS'(in_record_word);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_placed_slot = placed_r;
  assign out_read_word   = rword_r;

endmodule
`default_nettype wire
